// File: rtl/scla_pkg.sv
// Shared types and constants of the serial command line assembler.
package scla_pkg;

    localparam int BYTE_W = 8;
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
    localparam logic [8:0] MAX_RESULTS = 9'd31;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic accept;
        logic fetch;
        logic load_char;
    } ctrl_cmd_t;

    typedef struct packed {
        logic stream_start;
        logic can_load;
        logic char_last;
    } dp_status_t;

endpackage

// File: rtl/scla_dp.sv
// Datapath of the command line assembler: line store, line state, read counter and result register.
module scla_dp
    import scla_pkg::*;
#(
    parameter int LINE_CAPACITY = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        status,
    input  logic              action,
    input  logic [BYTE_W-1:0] byte_value,
    input  logic [BYTE_W-1:0] read_limit,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              accepted,
    output logic              char_valid,
    output logic [BYTE_W-1:0] char_value,
    output logic              last,
    output logic              line_ready
);

    localparam int LW = $clog2(LINE_CAPACITY);
    localparam logic [LW-1:0] LAST_POS = LW'(LINE_CAPACITY - 1);

    logic [BYTE_W-1:0] mem [LINE_CAPACITY];
    logic [BYTE_W-1:0] rd_data_reg;

    logic [LW-1:0] len_reg, len_next;
    logic          ready_reg, ready_next;
    logic          discard_reg, discard_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [LW-1:0] count_reg, count_next;

    logic              out_valid_reg, out_valid_next;
    logic              accepted_reg, accepted_next;
    logic              char_valid_reg, char_valid_next;
    logic [BYTE_W-1:0] char_value_reg, char_value_next;
    logic              last_reg, last_next;
    logic              line_ready_reg, line_ready_next;

    logic          delim;
    logic          mem_we;
    logic          refused;
    logic [8:0]    len9;
    logic [8:0]    lim9;
    logic [8:0]    cnt_a;
    logic [8:0]    cnt_b;
    logic [LW-1:0] read_count;
    logic          out_taken;

    assign delim = (byte_value == CHAR_CR) || (byte_value == CHAR_LF);
    assign refused = !ready_reg || (read_limit == '0);
    assign len9 = {{(9 - LW){1'b0}}, len_reg};
    assign lim9 = {1'b0, read_limit};
    assign cnt_a = (len9 >= lim9) ? (lim9 - 9'd1) : len9;
    assign cnt_b = (cnt_a > MAX_RESULTS) ? MAX_RESULTS : cnt_a;
    assign read_count = cnt_b[LW-1:0];
    assign out_taken = out_valid_reg && !out_stall;

    assign status.stream_start = (action == ACT_READ) && !refused && (read_count != '0);
    assign status.can_load = !out_valid_reg || !out_stall;
    assign status.char_last = ({1'b0, idx_reg} + (LW + 1)'(1)) == {1'b0, count_reg};

    always_comb
    begin
        len_next = len_reg;
        ready_next = ready_reg;
        discard_next = discard_reg;
        idx_next = idx_reg;
        count_next = count_reg;
        mem_we = 1'b0;
        out_valid_next = out_taken ? 1'b0 : out_valid_reg;
        accepted_next = accepted_reg;
        char_valid_next = char_valid_reg;
        char_value_next = char_value_reg;
        last_next = last_reg;
        line_ready_next = line_ready_reg;

        if (cmd.accept)
        begin
            if (action == ACT_BYTE)
            begin
                priority if (ready_reg)
                begin
                    discard_next = !delim;
                end
                else if (discard_reg)
                begin
                    if (delim)
                    begin
                        discard_next = 1'b0;
                    end
                end
                else if (delim)
                begin
                    if (len_reg != '0)
                    begin
                        ready_next = 1'b1;
                    end
                end
                else if (len_reg < LAST_POS)
                begin
                    mem_we = 1'b1;
                    len_next = len_reg + LW'(1);
                end
                else
                begin
                    len_next = '0;
                    discard_next = 1'b1;
                end
                out_valid_next = 1'b1;
                accepted_next = 1'b1;
                char_valid_next = 1'b0;
                char_value_next = '0;
                last_next = 1'b1;
                line_ready_next = ready_next;
            end
            else if (refused)
            begin
                out_valid_next = 1'b1;
                accepted_next = 1'b0;
                char_valid_next = 1'b0;
                char_value_next = '0;
                last_next = 1'b1;
                line_ready_next = ready_reg;
            end
            else
            begin
                len_next = '0;
                ready_next = 1'b0;
                idx_next = '0;
                count_next = read_count;
                if (read_count == '0)
                begin
                    out_valid_next = 1'b1;
                    accepted_next = 1'b1;
                    char_valid_next = 1'b0;
                    char_value_next = '0;
                    last_next = 1'b1;
                    line_ready_next = 1'b0;
                end
            end
        end

        if (cmd.load_char)
        begin
            out_valid_next = 1'b1;
            accepted_next = 1'b1;
            char_valid_next = 1'b1;
            char_value_next = rd_data_reg;
            last_next = status.char_last;
            line_ready_next = 1'b0;
            idx_next = idx_reg + LW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[len_reg] <= byte_value;
        end
        if (cmd.fetch)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            ready_reg <= 1'b0;
            discard_reg <= 1'b0;
            idx_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            ready_reg <= ready_next;
            discard_reg <= discard_next;
            idx_reg <= idx_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accepted_reg <= accepted_next;
        char_valid_reg <= char_valid_next;
        char_value_reg <= char_value_next;
        last_reg <= last_next;
        line_ready_reg <= line_ready_next;
    end

    assign out_valid = out_valid_reg;
    assign accepted = accepted_reg;
    assign char_valid = char_valid_reg;
    assign char_value = char_value_reg;
    assign last = last_reg;
    assign line_ready = line_ready_reg;

endmodule

// File: rtl/scla_ctrl.sv
// Controller state machine of the command line assembler.
module scla_ctrl
    import scla_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_LOAD  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = !((state_reg == ST_IDLE) && status.can_load);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.can_load)
                begin
                    cmd.accept = 1'b1;
                    if (status.stream_start)
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.can_load)
                begin
                    cmd.load_char = 1'b1;
                    state_next = status.char_last ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/serial_command_line_assembler_top.sv
// Top level of the serial command line assembler.
// Input channel (in_valid, in_stall): action, byte_value, read_limit. A received byte
// (action 0) is appended to the current line, unless dropped while a completed line waits
// or after an overflow; CR or LF completes a non-empty line. A read (action 1) streams the
// completed line, up to read_limit-1 characters. Output channel (out_valid, out_stall): one
// result per byte item, refused read or read of no characters, and one result per character
// otherwise; last marks the final result of an item. The result of a byte item or a refused
// read is registered and appears the cycle after the transfer. A read passes through a fetch
// state and a load state for each character, set by the registered read port of the line
// store; the load waits while the receiver stalls the result register. Only one item is in
// progress at a time; while the result register holds a result the receiver has not taken,
// in_stall stays high and no new item is accepted. Reset clears the line length, the ready and
// discard flags and the output valid; the line store is not cleared and needs no clearing pass.
module serial_command_line_assembler_top
    import scla_pkg::*;
#(
    parameter int LINE_CAPACITY = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    input  logic [BYTE_W-1:0] byte_value,
    input  logic [BYTE_W-1:0] read_limit,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              accepted,
    output logic              char_valid,
    output logic [BYTE_W-1:0] char_value,
    output logic              last,
    output logic              line_ready
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    scla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    scla_dp #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .action     (action),
        .byte_value (byte_value),
        .read_limit (read_limit),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .accepted   (accepted),
        .char_valid (char_valid),
        .char_value (char_value),
        .last       (last),
        .line_ready (line_ready)
    );

endmodule
